// ===== rtl/gcbk_pkg.sv =====
// ----------------------------------------------------------------------------
// gcbk_pkg: shared types and constants for the grid-cell keypoint keeper
// Holds action codes, register indexes, the queue entry type and state enums.
// ----------------------------------------------------------------------------
package gcbk_pkg;

  localparam int MaxCellsDefault = 4096;
  localparam int CfgWidth        = 9;

  localparam logic [1:0] ActAdd    = 2'd0;
  localparam logic [1:0] ActClear  = 2'd1;
  localparam logic [1:0] ActRead   = 2'd2;
  localparam logic [1:0] ActUnused = 2'd3;

  localparam logic [1:0] RegCellWidth  = 2'd0;
  localparam logic [1:0] RegCellHeight = 2'd1;
  localparam logic [1:0] RegGridCols   = 2'd2;
  localparam logic [1:0] RegGridRows   = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_CLEAR,
    OP_READ,
    OP_NONE
  } op_t;

  // Front to back queue entry. The cell index keeps 17 bits so that
  // any index at or above the cell count is still recognized.
  typedef struct packed {
    op_t          op;
    logic         oob;
    logic [16:0]  cell_idx;
    logic [15:0]  pos_x;
    logic [15:0]  pos_y;
    logic [31:0]  score;
    logic [3:0]   level;
  } job_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_XDIV,
    FR_YDIV,
    FR_MUL,
    FR_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_LOOK,
    BK_DECIDE,
    BK_CLEAR,
    BK_OUT
  } back_state_t;

  function automatic logic [8:0] eff_reg(input logic [8:0] v);
    logic [8:0] r;
    begin
      r = v;
      if (v == 9'd0) r = 9'd1;
      else if (v > 9'd256) r = 9'd256;
      return r;
    end
  endfunction

endpackage

// ===== rtl/gcbk_front.sv =====
// ----------------------------------------------------------------------------
// gcbk_front: accepts items and works out their grid cell
// Divides the coordinates by sixteen times the cell width or height with a restoring divider,
// one quotient bit per cycle, then forms and range checks the cell index.
// ----------------------------------------------------------------------------
module gcbk_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  output logic                 ready,
  input  logic [1:0]           action,
  input  logic [15:0]          pos_x,
  input  logic [15:0]          pos_y,
  input  logic [31:0]          score,
  input  logic [3:0]           level,
  input  logic [11:0]          read_index,
  input  logic [8:0]           cell_width,
  input  logic [8:0]           cell_height,
  input  logic [8:0]           grid_cols,
  input  logic [8:0]           grid_rows,
  input  logic [16:0]          max_cells,
  output logic                 job_valid,
  input  logic                 job_ready,
  output gcbk_pkg::job_t       job
);
  import gcbk_pkg::*;

  front_state_t state, state_next;
  job_t         cur;
  logic [15:0]  dividend;
  logic [12:0]  divisor;
  logic [15:0]  rem;
  logic [15:0]  quot;
  logic [3:0]   bit_cnt;
  logic [15:0]  col;
  logic [15:0]  row;
  logic [8:0]   cols_eff;
  logic [8:0]   rows_eff;
  logic [16:0]  rem_sh;
  logic         rem_ge;
  logic [24:0]  prod;
  logic [25:0]  idx_full;
  logic         dim_oob;

  assign cols_eff = eff_reg(grid_cols);
  assign rows_eff = eff_reg(grid_rows);
  assign rem_sh   = {rem, dividend[15]};
  assign rem_ge   = rem_sh >= {4'd0, divisor};
  assign prod     = row * cols_eff;
  assign idx_full = {1'b0, prod} + {10'd0, col};
  assign dim_oob  = (col >= {7'd0, cols_eff}) || (row >= {7'd0, rows_eff});

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: if (valid) begin
        if (action == ActAdd) state_next = FR_XDIV;
        else state_next = FR_PUSH;
      end
      FR_XDIV: if (bit_cnt == 4'd15) state_next = FR_YDIV;
      FR_YDIV: if (bit_cnt == 4'd15) state_next = FR_MUL;
      FR_MUL:  state_next = FR_PUSH;
      FR_PUSH: if (job_ready) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    ready     = (state == FR_IDLE);
    job_valid = (state == FR_PUSH);
    job       = cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      FR_IDLE: if (valid) begin
        cur.pos_x    <= pos_x;
        cur.pos_y    <= pos_y;
        cur.score    <= score;
        cur.level    <= level;
        cur.oob      <= 1'b0;
        cur.cell_idx <= {5'd0, read_index};
        dividend     <= pos_x;
        divisor      <= {eff_reg(cell_width), 4'd0};
        rem          <= '0;
        bit_cnt      <= '0;
        case (action)
          ActAdd:   cur.op <= OP_ADD;
          ActClear: cur.op <= OP_CLEAR;
          ActRead: begin
            cur.op  <= OP_READ;
            cur.oob <= ({5'd0, read_index} >= max_cells) ||
                       ({5'd0, read_index} >= {8'd0, rows_eff} * {8'd0, cols_eff});
          end
          default:  cur.op <= OP_NONE;
        endcase
      end
      FR_XDIV, FR_YDIV: begin
        quot    <= {quot[14:0], rem_ge};
        bit_cnt <= bit_cnt + 4'd1;
        if (bit_cnt == 4'd15 && state == FR_XDIV) begin
          // column done, start the row division
          col      <= {quot[14:0], rem_ge};
          dividend <= cur.pos_y;
          divisor  <= {eff_reg(cell_height), 4'd0};
          rem      <= '0;
        end else begin
          rem      <= rem_ge ? 16'(rem_sh - {4'd0, divisor}) : rem_sh[15:0];
          dividend <= {dividend[14:0], 1'b0};
          if (bit_cnt == 4'd15) row <= {quot[14:0], rem_ge};
        end
      end
      FR_MUL: begin
        cur.cell_idx <= idx_full[16:0];
        cur.oob      <= dim_oob || (idx_full >= {9'd0, max_cells});
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/gcbk_queue.sv =====
// ----------------------------------------------------------------------------
// gcbk_queue: two-entry queue between the front and back parts
// A small FIFO so either side can stall without holding the other.
// ----------------------------------------------------------------------------
module gcbk_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gcbk_pkg::job_t in_job,
  output logic           out_valid,
  input  logic           out_ready,
  output gcbk_pkg::job_t out_job
);
  import gcbk_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_job   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/gcbk_back.sv =====
// ----------------------------------------------------------------------------
// gcbk_back: carries out add, clear and read on the cell store
// Holds the keypoint memory, the occupied bits and the occupied count.
// A clear sweeps the occupied bits one cell per cycle.
// ----------------------------------------------------------------------------
module gcbk_back #(
  parameter int MaxCells = gcbk_pkg::MaxCellsDefault,
  parameter int AddrW    = (MaxCells > 1) ? $clog2(MaxCells) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  gcbk_pkg::job_t       job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 stored,
  output logic                 out_of_grid,
  output logic [11:0]          cell_number,
  output logic [12:0]          occupied_count,
  output logic                 cell_valid,
  output logic [15:0]          cell_x,
  output logic [15:0]          cell_y,
  output logic [31:0]          cell_score,
  output logic [3:0]           cell_level
);
  import gcbk_pkg::*;

  back_state_t   state, state_next;
  job_t          cur;
  logic [31:0]   pos_mem   [MaxCells];
  logic [31:0]   score_mem [MaxCells];
  logic [3:0]    level_mem [MaxCells];
  logic [0:0]    occ_mem   [MaxCells];
  logic [31:0]   rd_pos;
  logic [31:0]   rd_score;
  logic [3:0]    rd_level;
  logic          rd_occ;
  logic [AddrW-1:0] addr;
  logic [AddrW:0]   sweep;
  logic          sweep_last;
  logic [12:0]   filled;
  logic          wins;

  assign addr       = cur.cell_idx[AddrW-1:0];
  assign wins       = !rd_occ || ($signed(rd_score) < $signed(cur.score));
  assign sweep_last = (sweep == (AddrW+1)'(MaxCells - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_INIT:   if (sweep_last) state_next = BK_IDLE;
      BK_IDLE: if (job_valid) begin
        if (job.op == OP_CLEAR) state_next = BK_CLEAR;
        else state_next = BK_LOOK;
      end
      BK_LOOK:   state_next = BK_DECIDE;
      BK_DECIDE: state_next = BK_OUT;
      BK_CLEAR:  if (sweep_last) state_next = BK_OUT;
      BK_OUT:    if (out_ready) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state == BK_IDLE);
    out_valid = (state == BK_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Registered memory reads
  always_ff @(posedge clk) begin
    rd_pos   <= pos_mem[addr];
    rd_score <= score_mem[addr];
    rd_level <= level_mem[addr];
    rd_occ   <= occ_mem[addr][0];
  end

  always_ff @(posedge clk) begin
    if (state == BK_DECIDE && cur.op == OP_ADD && !cur.oob && wins) begin
      pos_mem[addr]   <= {cur.pos_y, cur.pos_x};
      score_mem[addr] <= cur.score;
      level_mem[addr] <= cur.level;
    end
  end

  // Occupied bits: a clear sweep owns the write port while it runs
  always_ff @(posedge clk) begin
    if (state == BK_CLEAR || state == BK_INIT) begin
      occ_mem[sweep[AddrW-1:0]] <= 1'b0;
    end else if (state == BK_DECIDE && cur.op == OP_ADD && !cur.oob) begin
      occ_mem[addr] <= 1'b1;
    end
  end

  // Reset runs the same sweep before the first item
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      sweep  <= '0;
    end else if (state == BK_IDLE && job_valid && job.op == OP_CLEAR) begin
      sweep  <= '0;
      filled <= '0;
    end else if (state == BK_CLEAR || state == BK_INIT) begin
      sweep <= sweep + (AddrW+1)'(1);
    end else if (state == BK_DECIDE && cur.op == OP_ADD && !cur.oob && !rd_occ) begin
      filled <= filled + 13'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && job_valid) cur <= job;
    if (state == BK_DECIDE || (state == BK_CLEAR && state_next == BK_OUT)) begin
      stored      <= 1'b0;
      out_of_grid <= 1'b0;
      cell_number <= 12'd0;
      cell_valid  <= 1'b0;
      cell_x      <= '0;
      cell_y      <= '0;
      cell_score  <= '0;
      cell_level  <= '0;
      case (cur.op)
        OP_ADD: begin
          cell_number <= cur.cell_idx[11:0];
          out_of_grid <= cur.oob;
          stored      <= !cur.oob && wins;
        end
        OP_READ: begin
          cell_number <= cur.cell_idx[11:0];
          out_of_grid <= cur.oob;
          if (!cur.oob && rd_occ) begin
            cell_valid <= 1'b1;
            cell_x     <= rd_pos[15:0];
            cell_y     <= rd_pos[31:16];
            cell_score <= rd_score;
            cell_level <= rd_level;
          end
        end
        default: ;
      endcase
    end
  end

  assign occupied_count = filled;

endmodule

// ===== rtl/grid_cell_best_keypoint.sv =====
// ----------------------------------------------------------------------------
// grid_cell_best_keypoint: keeps the strongest keypoint of each grid cell
// Add, clear and read items in; one result item out for every item in.
// ----------------------------------------------------------------------------
// Input channel (valid/ready): action, pos_x, pos_y, score, level, read_index.
// Output channel (out_valid/out_ready): one result per item, in order.
// Configuration: cfg_we with cfg_index and cfg_data writes a register at once;
// write only while no item is in flight.
// The front part takes an item and, for add, finds the cell with a bit-serial
// divider for column and row and a multiply; it takes no new item until it has
// passed the current one on to the queue.
// The back part handles each item in the steps accept, look up, decide and
// output, holding the result until out_ready; a clear sweeps the occupied bits.
// A two-entry queue separates the parts, so the front keeps taking items while
// a result waits on out_ready; once front and queue are full the input stalls.
// Reset clears the control state and the count, then sweeps the occupied
// bits; items taken meanwhile wait in the queue.
// Empty cells are told apart by occupied bits, so old contents never show.
// ----------------------------------------------------------------------------
module grid_cell_best_keypoint #(
  parameter int MaxCells = gcbk_pkg::MaxCellsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         valid,
  output logic         ready,
  input  logic [1:0]   action,
  input  logic [15:0]  pos_x,
  input  logic [15:0]  pos_y,
  input  logic [31:0]  score,
  input  logic [3:0]   level,
  input  logic [11:0]  read_index,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         stored,
  output logic         out_of_grid,
  output logic [11:0]  cell_number,
  output logic [12:0]  occupied_count,
  output logic         cell_valid,
  output logic [15:0]  cell_x,
  output logic [15:0]  cell_y,
  output logic [31:0]  cell_score,
  output logic [3:0]   cell_level,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [8:0]   cfg_data
);
  import gcbk_pkg::*;

  logic [8:0] cell_width_r;
  logic [8:0] cell_height_r;
  logic [8:0] grid_cols_r;
  logic [8:0] grid_rows_r;
  logic       fq_valid;
  logic       fq_ready;
  job_t       fq_job;
  logic       qb_valid;
  logic       qb_ready;
  job_t       qb_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width_r  <= 9'd32;
      cell_height_r <= 9'd32;
      grid_cols_r   <= 9'd20;
      grid_rows_r   <= 9'd15;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegCellWidth:  cell_width_r  <= cfg_data;
        RegCellHeight: cell_height_r <= cfg_data;
        RegGridCols:   grid_cols_r   <= cfg_data;
        RegGridRows:   grid_rows_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  gcbk_front u_front (
    .clk, .rst, .valid, .ready, .action, .pos_x, .pos_y, .score, .level,
    .read_index,
    .cell_width  (cell_width_r),
    .cell_height (cell_height_r),
    .grid_cols   (grid_cols_r),
    .grid_rows   (grid_rows_r),
    .max_cells   (17'(MaxCells)),
    .job_valid   (fq_valid),
    .job_ready   (fq_ready),
    .job         (fq_job)
  );

  gcbk_queue u_queue (
    .clk, .rst,
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_job    (fq_job),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_job   (qb_job)
  );

  gcbk_back #(.MaxCells(MaxCells)) u_back (
    .clk, .rst,
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .out_valid, .out_ready, .stored, .out_of_grid, .cell_number,
    .occupied_count, .cell_valid, .cell_x, .cell_y, .cell_score, .cell_level
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for grid_cell_best_keypoint
// Drives add, clear, read and unused items over several grid setups, keeps its
// own copy of the cell store and compares every result field against it.
// ----------------------------------------------------------------------------
import gcbk_pkg::*;

typedef struct packed {
  logic [1:0]  action;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [31:0] score;
  logic [3:0]  level;
  logic [11:0] read_index;
} kp_item_t;

typedef struct packed {
  logic        stored;
  logic        out_of_grid;
  logic [11:0] cell_number;
  logic [12:0] occupied_count;
  logic        cell_valid;
  logic [15:0] cell_x;
  logic [15:0] cell_y;
  logic [31:0] cell_score;
  logic [3:0]  cell_level;
} kp_result_t;

class cell_store_scoreboard;
  logic [8:0]  regs [4];
  logic        occ [4096];
  logic [15:0] px [4096];
  logic [15:0] py [4096];
  logic [31:0] sc [4096];
  logic [3:0]  lv [4096];
  int          filled;
  kp_result_t  pending [$];
  int          mismatches;
  int          n_add, n_clear, n_read, n_other, n_stored, n_oob, n_checked;

  function new();
    regs[RegCellWidth]  = 9'd32;
    regs[RegCellHeight] = 9'd32;
    regs[RegGridCols]   = 9'd20;
    regs[RegGridRows]   = 9'd15;
    foreach (occ[i]) occ[i] = 1'b0;
    filled = 0;
    mismatches = 0;
  endfunction

  function int clamp_reg(logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  function void note_item(kp_item_t it);
    kp_result_t r;
    int cols, rows, col, row, idx;
    r = '0;
    cols = clamp_reg(regs[RegGridCols]);
    rows = clamp_reg(regs[RegGridRows]);
    case (it.action)
      ActAdd: begin
        n_add++;
        col = int'(it.pos_x) / (16 * clamp_reg(regs[RegCellWidth]));
        row = int'(it.pos_y) / (16 * clamp_reg(regs[RegCellHeight]));
        idx = row * cols + col;
        r.cell_number = idx[11:0];
        if (col >= cols || row >= rows || idx >= 4096) begin
          r.out_of_grid = 1'b1;
          n_oob++;
        end else if (!occ[idx] || $signed(sc[idx]) < $signed(it.score)) begin
          if (!occ[idx]) begin
            occ[idx] = 1'b1;
            filled++;
          end
          px[idx] = it.pos_x;
          py[idx] = it.pos_y;
          sc[idx] = it.score;
          lv[idx] = it.level;
          r.stored = 1'b1;
          n_stored++;
        end
      end
      ActClear: begin
        n_clear++;
        foreach (occ[i]) occ[i] = 1'b0;
        filled = 0;
      end
      ActRead: begin
        n_read++;
        idx = int'(it.read_index);
        r.cell_number = it.read_index;
        if (idx >= rows * cols) begin
          r.out_of_grid = 1'b1;
          n_oob++;
        end else if (occ[idx]) begin
          r.cell_valid = 1'b1;
          r.cell_x = px[idx];
          r.cell_y = py[idx];
          r.cell_score = sc[idx];
          r.cell_level = lv[idx];
        end
      end
      default: n_other++;
    endcase
    r.occupied_count = filled[12:0];
    pending.push_back(r);
  endfunction

  function void check_result(kp_result_t got);
    kp_result_t want;
    n_checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch at result %0d\n  exp %p\n  got %p",
                                     n_checked, want, got);
    end
  endfunction
endclass

module tb;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        ready;
  logic [1:0]  action = '0;
  logic [15:0] pos_x = '0;
  logic [15:0] pos_y = '0;
  logic [31:0] score = '0;
  logic [3:0]  level = '0;
  logic [11:0] read_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        stored, out_of_grid, cell_valid;
  logic [11:0] cell_number;
  logic [12:0] occupied_count;
  logic [15:0] cell_x, cell_y;
  logic [31:0] cell_score;
  logic [3:0]  cell_level;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;

  int send_idle = 0;
  int recv_idle = 0;
  int hold_off = 0;
  cell_store_scoreboard sb;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  grid_cell_best_keypoint u_top (.*);

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{stored, out_of_grid, cell_number, occupied_count, cell_valid,
                        cell_x, cell_y, cell_score, cell_level});
  end

  task automatic send_item(kp_item_t it);
    @(negedge clk);
    valid <= 1'b1;
    action <= it.action;
    pos_x <= it.pos_x;
    pos_y <= it.pos_y;
    score <= it.score;
    level <= it.level;
    read_index <= it.read_index;
    do @(posedge clk); while (!ready);
    sb.note_item(it);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      valid <= 1'b0;
    end
  endtask

  // drop valid before waiting so the last item is not taken twice
  task automatic drain();
    @(negedge clk);
    valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    @(negedge clk);
    valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.regs[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic kp_item_t make_add(int x, int y, logic [31:0] s, logic [3:0] l);
    kp_item_t it;
    it = '0;
    it.action = ActAdd;
    it.pos_x = x[15:0];
    it.pos_y = y[15:0];
    it.score = s;
    it.level = l;
    return it;
  endfunction

  function automatic kp_item_t make_read(int idx);
    kp_item_t it;
    it = '0;
    it.action = ActRead;
    it.read_index = idx[11:0];
    return it;
  endfunction

  // Bias toward cells inside the grid and a few hot cells so replacement is exercised.
  function automatic kp_item_t random_item();
    kp_item_t it;
    logic [95:0] raw;
    int sel, cols, rows, cw, ch, col, row, x, y;
    raw = {$urandom, $urandom, $urandom};
    it = raw[81:0];
    sel = $urandom_range(99);
    cols = sb.clamp_reg(sb.regs[RegGridCols]);
    rows = sb.clamp_reg(sb.regs[RegGridRows]);
    cw = 16 * sb.clamp_reg(sb.regs[RegCellWidth]);
    ch = 16 * sb.clamp_reg(sb.regs[RegCellHeight]);
    if (sel < 2) begin
      it.action = ActClear;
    end else if (sel < 5) begin
      it.action = ActUnused;
    end else if (sel < 35) begin
      it.action = ActRead;
      if ($urandom_range(3) != 0) it.read_index = 12'($urandom_range(
          ((rows * cols > 4096) ? 4096 : rows * cols) - 1));
    end else begin
      it.action = ActAdd;
      if (sel < 88) begin
        col = ($urandom_range(1)) ? $urandom_range((cols < 4 ? cols : 4) - 1)
                                  : $urandom_range(cols - 1);
        row = ($urandom_range(1)) ? $urandom_range((rows < 4 ? rows : 4) - 1)
                                  : $urandom_range(rows - 1);
        x = col * cw + $urandom_range(cw - 1);
        y = row * ch + $urandom_range(ch - 1);
        if (x <= 65535) it.pos_x = x[15:0];
        if (y <= 65535) it.pos_y = y[15:0];
        if ($urandom_range(2) == 0) it.score = $signed($urandom_range(2000)) - 1000;
      end
    end
    return it;
  endfunction

  initial begin
    #20_000_000;
    $display("** grid_cell_best_keypoint: FAILED **");
    $finish;
  end

  initial begin
    int cfgs [8][4];
    int nph;
    sb = new();
    cfgs = '{'{32, 32, 20, 15}, '{1, 1, 256, 256}, '{256, 256, 1, 1}, '{0, 0, 0, 0},
             '{511, 300, 16, 16}, '{8, 4, 64, 64}, '{3, 5, 300, 200}, '{16, 16, 40, 30}};
    nph = 8;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty store after reset, then edges and replacement rules
    send_item(make_read(0));
    send_item('{ActClear, 16'h0, 16'h0, 32'h0, 4'h0, 12'h0});
    send_item(make_add(0, 0, 32'h7FFF_FFFF, 4'hF));
    send_item(make_add(5, 7, 32'h7FFF_FFFF, 4'h1));
    send_item(make_add(16, 16, 32'h1000_0000, 4'h2));
    send_item(make_add(600, 600, 32'h8000_0000, 4'h0));
    send_item(make_add(600, 601, 32'h8000_0001, 4'h3));
    send_item(make_add(600, 602, 32'h8000_0001, 4'h4));
    send_item(make_add(65535, 65535, 32'h1, 4'h5));
    send_item(make_add(65535, 0, 32'h1, 4'h5));
    send_item(make_add(0, 65535, 32'h1, 4'h5));
    send_item(make_add(20 * 512 - 1, 15 * 512 - 1, 32'hFFFF_FFFF, 4'hA));
    send_item(make_read(0));
    send_item(make_read(21));
    send_item(make_read(299));
    send_item(make_read(300));
    send_item(make_read(4095));
    send_item(make_read(1));
    send_item('{ActUnused, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, 12'hFFF});
    send_item('{ActClear, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, 12'hFFF});
    send_item(make_read(0));
    send_item(make_add(0, 0, 32'h8000_0000, 4'h7));
    send_item(make_read(0));

    for (int p = 0; p < nph; p++) begin
      drain();
      if (p > 0) for (int r = 0; r < 4; r++) write_reg(r[1:0], cfgs[p][r][8:0]);
      case (p * 3 / nph)
        0: begin send_idle = 6; recv_idle = 80; end
        1: begin send_idle = 80; recv_idle = 6; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (p == 1) hold_off = 400;
      repeat (150) send_item(random_item());
    end
    drain();

    $display("covered %0d adds (%0d stored), %0d reads, %0d clears, %0d unused codes",
             sb.n_add, sb.n_stored, sb.n_read, sb.n_clear, sb.n_other);
    $display("%0d results checked, %0d outside the grid, %0d grid setups",
             sb.n_checked, sb.n_oob, nph);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("** grid_cell_best_keypoint: PASSED **");
    end else begin
      $display("** grid_cell_best_keypoint: FAILED **");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/gcbk_pkg.sv
rtl/gcbk_front.sv
rtl/gcbk_queue.sv
rtl/gcbk_back.sv
rtl/grid_cell_best_keypoint.sv
bench/tb.sv
